// ===== hdl/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package skt_pkg;

    // Command codes on the request channel.
    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_CHANGE = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_RANGE  = 3'd4;
    // Internal class for the unused command codes.
    localparam logic [2:0] CMD_NOP    = 3'd5;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    // Entry count that raises the underfull flag.
    localparam int UNDERFULL_COUNT = 3;

    // One request as it arrives.
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  key;
        logic [7:0]  key_end;
        logic [31:0] child_in;
    } req_t;

    // One result as it leaves.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  key_out;
        logic [31:0] child_out;
        logic [4:0]  entry_count;
        logic        full_res;
        logic        underfull;
        logic        last;
    } rsp_t;

    // A classified request as it sits in the queue between front and back.
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  key;
        logic [7:0]  key_end;
        logic [31:0] child;
    } op_req_t;

    // Queue handshake from the front to the back.
    typedef struct packed {
        logic    valid;
        op_req_t req;
    } queue_head_t;

endpackage

// ===== hdl/sorted_key_table_16_top.sv =====
// Sorted key table, top level: front queue and back sequencer.
// Depends on skt_pkg, skt_front and skt_back.
//
// Usage: requests arrive on req_valid/req_stall/req_data and results leave on
// rsp_valid/rsp_stall/rsp_data. A request is taken on a rising edge with valid
// high and stall low. Lookup, insert, change, remove and unused commands give
// one result with last set; a range read gives one result per entry in the
// range, with last on the final one, or a single empty-range result.
// Path: a request passes from its queue slot through the sequencer's idle
// state (search and pop) and execute state into the result register.
// The sequencer takes one request at a time and pops the next only when it
// is idle again; the queue keeps accepting meanwhile. A range read then
// emits its entries from the range state.
// Reset empties the table (entry count zero) and the request queue and drops
// any pending result. When the receiver stalls, the result register holds its
// value, the sequencer waits, and up to two requests collect in the queue
// before req_stall rises.
module sorted_key_table_16_top
#(
    parameter int ENTRIES     = 16,
    parameter int CHILD_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  skt_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output skt_pkg::rsp_t rsp_data
);

    skt_pkg::queue_head_t head;
    logic                 pop;

    // Request intake and queue.
    skt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .head      (head),
        .pop       (pop)
    );

    // Table and sequencer.
    skt_back
    #(
        .ENTRIES     (ENTRIES),
        .CHILD_WIDTH (CHILD_WIDTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== hdl/skt_front.sv =====
// Front end of the sorted key table: accepts requests, classifies the command
// and holds them in a two-entry queue. Depends on skt_pkg.
module skt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  skt_pkg::req_t         req_data,
    output skt_pkg::queue_head_t  head,
    input  logic                  pop
);

    skt_pkg::op_req_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             push;
    logic             do_pop;
    skt_pkg::op_req_t classified;

    // The queue refuses requests only when both slots are taken.
    assign req_stall = (fill_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign do_pop    = pop && (fill_reg != 2'd0);

    // Sort the command into an operation class; unused codes become no-ops.
    always_comb
    begin
        classified.key     = req_data.key;
        classified.key_end = req_data.key_end;
        classified.child   = req_data.child_in;
        unique case (req_data.command)
            skt_pkg::CMD_LOOKUP: classified.op = skt_pkg::CMD_LOOKUP;
            skt_pkg::CMD_INSERT: classified.op = skt_pkg::CMD_INSERT;
            skt_pkg::CMD_CHANGE: classified.op = skt_pkg::CMD_CHANGE;
            skt_pkg::CMD_REMOVE: classified.op = skt_pkg::CMD_REMOVE;
            skt_pkg::CMD_RANGE:  classified.op = skt_pkg::CMD_RANGE;
            default:             classified.op = skt_pkg::CMD_NOP;
        endcase
    end

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue slots hold payload only and need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.req   = slot_reg[rd_ptr_reg];

endmodule

// ===== hdl/skt_back.sv =====
// Back end of the sorted key table: the entry cells with parallel compare and
// shift, the operation sequencer and the result register. Depends on skt_pkg.
module skt_back
#(
    parameter int ENTRIES     = 16,
    parameter int CHILD_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  skt_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output skt_pkg::rsp_t        rsp_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RANGE = 2'd2;

    // Table cells.
    logic [7:0]             key_store_reg    [ENTRIES];
    logic [7:0]             key_store_next   [ENTRIES];
    logic [CHILD_WIDTH-1:0] child_store_reg  [ENTRIES];
    logic [CHILD_WIDTH-1:0] child_store_next [ENTRIES];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    // Sequencer state and the operation in flight.
    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [2:0]             op_reg;
    logic [7:0]             op_key_reg;
    logic [CHILD_WIDTH-1:0] op_child_reg;
    logic [IW-1:0]          s_pos_reg;
    logic [IW-1:0]          e_pos_reg;
    logic [IW-1:0]          ins_pos_reg;
    logic                   found_reg;
    logic                   s_le_e_reg;
    logic [IW-1:0]          ptr_reg;
    logic [IW-1:0]          ptr_next;

    // Result register.
    logic                   rsp_valid_reg;
    skt_pkg::rsp_t          rsp_data_reg;
    skt_pkg::rsp_t          rsp_data_next;
    logic                   load;
    logic                   out_free;

    // Search results computed from the queue head.
    logic [ENTRIES-1:0]     match_k;
    logic [ENTRIES-1:0]     match_e;
    logic [ENTRIES-1:0]     greater;
    logic [IW-1:0]          first_k;
    logic [IW-1:0]          first_e;
    logic [IW-1:0]          first_gt;
    logic [IW-1:0]          s_pos;
    logic [IW-1:0]          e_pos;
    logic [IW-1:0]          ins_pos;
    logic [CHILD_WIDTH-1:0] head_child;

    logic [1:0]             res_status;
    logic [7:0]             res_key;
    logic [CHILD_WIDTH-1:0] res_child;
    logic                   res_last;
    logic [63:0]            res_child_wide;

    // Lowest set position of a vector; zero when none is set.
    function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign pop      = (state_reg == S_IDLE) && head.valid;

    assign head_child = CHILD_WIDTH'(head.req.child);

    // Parallel compare of every live entry against the start and end keys.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_k[i] = (CW'(i) < count_reg) && (key_store_reg[i] == head.req.key);
            match_e[i] = (CW'(i) < count_reg) && (key_store_reg[i] == head.req.key_end);
            greater[i] = (CW'(i) < count_reg) && (key_store_reg[i] > head.req.key);
        end
    end

    assign first_k  = first_set(match_k);
    assign first_e  = first_set(match_e);
    assign first_gt = first_set(greater);
    assign s_pos    = first_k;
    assign e_pos    = (|match_e) ? first_e : IW'(count_reg - CW'(1));
    assign ins_pos  = (|greater) ? first_gt : IW'(count_reg);

    // Table update, result selection and state sequencing.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_store_next[i]   = key_store_reg[i];
            child_store_next[i] = child_store_reg[i];
        end
        count_next = count_reg;
        state_next = state_reg;
        ptr_next   = ptr_reg;
        load       = 1'b0;
        res_status = skt_pkg::STATUS_OK;
        res_key    = 8'd0;
        res_child  = '0;
        res_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        skt_pkg::CMD_LOOKUP:
                        begin
                            if (found_reg)
                            begin
                                res_key   = key_store_reg[s_pos_reg];
                                res_child = child_store_reg[s_pos_reg];
                            end
                            else
                            begin
                                res_status = skt_pkg::STATUS_NOTFOUND;
                            end
                        end
                        skt_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CW'(ENTRIES))
                            begin
                                res_status = skt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                // Open a gap at the insert position and shift the tail up.
                                for (int i = 1; i < ENTRIES; i++)
                                begin
                                    if (IW'(i) > ins_pos_reg)
                                    begin
                                        key_store_next[i]   = key_store_reg[i-1];
                                        child_store_next[i] = child_store_reg[i-1];
                                    end
                                end
                                key_store_next[ins_pos_reg]   = op_key_reg;
                                child_store_next[ins_pos_reg] = op_child_reg;
                                count_next = count_reg + CW'(1);
                                res_key    = op_key_reg;
                                res_child  = op_child_reg;
                            end
                        end
                        skt_pkg::CMD_CHANGE:
                        begin
                            if (found_reg)
                            begin
                                child_store_next[s_pos_reg] = op_child_reg;
                                res_key   = op_key_reg;
                                res_child = op_child_reg;
                            end
                            else
                            begin
                                res_status = skt_pkg::STATUS_NOTFOUND;
                            end
                        end
                        skt_pkg::CMD_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                // Close the gap by shifting the tail down.
                                for (int i = 0; i < ENTRIES - 1; i++)
                                begin
                                    if (IW'(i) >= s_pos_reg)
                                    begin
                                        key_store_next[i]   = key_store_reg[i+1];
                                        child_store_next[i] = child_store_reg[i+1];
                                    end
                                end
                                count_next = count_reg - CW'(1);
                                res_key    = op_key_reg;
                                res_child  = child_store_reg[s_pos_reg];
                            end
                            else
                            begin
                                res_status = skt_pkg::STATUS_NOTFOUND;
                            end
                        end
                        skt_pkg::CMD_RANGE:
                        begin
                            if (count_reg == CW'(0) || !s_le_e_reg)
                            begin
                                res_status = skt_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // Entries stream out from the range state.
                                load       = 1'b0;
                                ptr_next   = s_pos_reg;
                                state_next = S_RANGE;
                            end
                        end
                        default:
                        begin
                            res_status = skt_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_RANGE:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    res_key   = key_store_reg[ptr_reg];
                    res_child = child_store_reg[ptr_reg];
                    res_last  = (ptr_reg == e_pos_reg);
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Assemble the result with the count as it stands after the operation.
    assign res_child_wide = 64'(res_child);

    always_comb
    begin
        rsp_data_next.status      = res_status;
        rsp_data_next.key_out     = res_key;
        rsp_data_next.child_out   = res_child_wide[31:0];
        rsp_data_next.entry_count = 5'(count_next);
        rsp_data_next.full_res    = (count_next == CW'(ENTRIES));
        rsp_data_next.underfull   = (count_next == CW'(skt_pkg::UNDERFULL_COUNT));
        rsp_data_next.last        = res_last;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: table cells, captured operation and result.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_store_reg[i]   <= key_store_next[i];
            child_store_reg[i] <= child_store_next[i];
        end
        ptr_reg <= ptr_next;
        if (pop)
        begin
            op_reg       <= head.req.op;
            op_key_reg   <= head.req.key;
            op_child_reg <= head_child;
            s_pos_reg    <= s_pos;
            e_pos_reg    <= e_pos;
            ins_pos_reg  <= ins_pos;
            found_reg    <= |match_k;
            s_le_e_reg   <= (s_pos <= e_pos);
        end
        if (load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
